@@ rtl/core/sacc_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sacc_pkg
// Types, constants and the arctangent table shared by the spiral arm
// cell classifier.
// ----------------------------------------------------------------------------
package sacc_pkg;

    // Signed CORDIC datapath width, sized for up to 8 pixels per cell.
    localparam int CW        = 32;
    // Angle width, Q0.32 turns.
    localparam int AW        = 32;
    // Fraction bits of pixel offsets entering the CORDIC.
    localparam int FRAC_BITS = 16;

    // Configuration port widths and register indexes.
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 18;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTRE_COL    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTRE_ROW    = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERSE_PITCH = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ARM_COUNT     = 8'd3;

    // Reset values of the configuration registers.
    localparam logic [8:0]  RST_CENTRE_COL    = 9'd40;
    localparam logic [7:0]  RST_CENTRE_ROW    = 8'd12;
    localparam logic [17:0] RST_INVERSE_PITCH = 18'd32768;
    localparam logic [3:0]  RST_ARM_COUNT     = 4'd1;

    // Arithmetic constants.
    localparam logic [AW-1:0] HALF_TURN  = 32'h8000_0000;
    // 1 / CORDIC gain in Q0.31, truncated.
    localparam logic [30:0]   INV_GAIN   = 31'h4DBA_76D4;
    // 3 pixels in Q.16.
    localparam logic [30:0]   MIN_RADIUS = 31'(3 << FRAC_BITS);
    // 0.2 rad in Q0.16 turns, and its mirror below a full turn.
    localparam logic [15:0]   ARM_LO     = 16'd2086;
    localparam logic [15:0]   ARM_HI     = 16'd63450;

    // Glyph codes.
    localparam logic [1:0] GLYPH_HORIZ = 2'd0;
    localparam logic [1:0] GLYPH_BACK  = 2'd1;
    localparam logic [1:0] GLYPH_VERT  = 2'd2;
    localparam logic [1:0] GLYPH_SLASH = 2'd3;

    typedef struct packed {
        logic [8:0]  centre_col;
        logic [7:0]  centre_row;
        logic [17:0] inverse_pitch;
        logic [3:0]  arm_count;
    } t_cfg;

    // CORDIC vector between stages.
    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic [AW-1:0]        z;
    } t_vec;

    typedef struct packed {
        logic       on_arm;
        logic [1:0] glyph;
        logic       near_centre;
    } t_result;

    // atan(2^-i) / (2*pi) in Q0.32 turns, rounded.
    function automatic logic [AW-1:0] atan_turn(input int idx);
        logic [AW-1:0] v;
        case (idx)
            0:       v = 32'h2000_0000;
            1:       v = 32'h12E4_051E;
            2:       v = 32'h09FB_385B;
            3:       v = 32'h0511_11D4;
            4:       v = 32'h028B_0D43;
            5:       v = 32'h0145_D7E1;
            6:       v = 32'h00A2_F61E;
            7:       v = 32'h0051_7C55;
            8:       v = 32'h0028_BE53;
            9:       v = 32'h0014_5F2F;
            10:      v = 32'h000A_2F98;
            11:      v = 32'h0005_17CC;
            12:      v = 32'h0002_8BE6;
            13:      v = 32'h0001_45F3;
            14:      v = 32'h0000_A2FA;
            15:      v = 32'h0000_517D;
            16:      v = 32'h0000_28BE;
            17:      v = 32'h0000_145F;
            18:      v = 32'h0000_0A30;
            19:      v = 32'h0000_0518;
            20:      v = 32'h0000_028C;
            21:      v = 32'h0000_0146;
            22:      v = 32'h0000_00A3;
            23:      v = 32'h0000_0051;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

@@ rtl/core/sacc_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sacc interfaces
// Valid/ready channels for cells, results and configuration writes.
// ----------------------------------------------------------------------------
interface sacc_cell_if;
    logic       valid;
    logic       ready;
    logic [8:0] cell_col;
    logic [7:0] cell_row;
    modport source (output valid, cell_col, cell_row, input ready);
    modport sink   (input valid, cell_col, cell_row, output ready);
endinterface

interface sacc_result_if;
    logic       valid;
    logic       ready;
    logic       on_arm;
    logic [1:0] glyph;
    logic       near_centre;
    modport source (output valid, on_arm, glyph, near_centre, input ready);
    modport sink   (input valid, on_arm, glyph, near_centre, output ready);
endinterface

interface sacc_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [sacc_pkg::CFG_IDX_W-1:0] index;
    logic [sacc_pkg::CFG_DAT_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ rtl/core/sacc_offset.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sacc_offset
// Pixel offset of a cell from the centre, scaled to Q.16, with the half
// turn pre-rotation for points left of the centre. One register stage.
// ----------------------------------------------------------------------------
module sacc_offset #(
    parameter int PIXELS_PER_COL = 2,
    parameter int PIXELS_PER_ROW = 4
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    output logic                 o_ready,
    input  wire  [8:0]           i_col,
    input  wire  [7:0]           i_row,
    input  wire  [8:0]           i_centre_col,
    input  wire  [7:0]           i_centre_row,
    output logic                 o_valid,
    input  wire                  i_ready,
    output sacc_pkg::t_vec       o_vec
);

    localparam int DW = 14;
    localparam int PW = sacc_pkg::CW - DW - sacc_pkg::FRAC_BITS;

    logic signed [9:0]  w_dcol;
    logic signed [8:0]  w_drow;
    logic signed [DW-1:0] w_dx;
    logic signed [DW-1:0] w_dy;
    logic signed [sacc_pkg::CW-1:0] w_xs;
    logic signed [sacc_pkg::CW-1:0] w_ys;
    sacc_pkg::t_vec n_vec;
    sacc_pkg::t_vec r_vec;
    logic r_v;

    // Offsets in pixels, then fixed point
    always_comb begin
        w_dcol = $signed({1'b0, i_col}) - $signed({1'b0, i_centre_col});
        w_drow = $signed({1'b0, i_row}) - $signed({1'b0, i_centre_row});
        w_dx   = DW'(w_dcol * PIXELS_PER_COL);
        w_dy   = DW'(w_drow * PIXELS_PER_ROW);
        w_xs   = {{PW{w_dx[DW-1]}}, w_dx, {sacc_pkg::FRAC_BITS{1'b0}}};
        w_ys   = {{PW{w_dy[DW-1]}}, w_dy, {sacc_pkg::FRAC_BITS{1'b0}}};
        if (w_dx[DW-1]) begin
            n_vec.x = -w_xs;
            n_vec.y = -w_ys;
            n_vec.z = sacc_pkg::HALF_TURN;
        end else begin
            n_vec.x = w_xs;
            n_vec.y = w_ys;
            n_vec.z = '0;
        end
    end

    assign o_ready = !r_v || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_ready) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_vec <= n_vec;
        end
    end

    assign o_valid = r_v;
    assign o_vec   = r_vec;

endmodule
`default_nettype wire

@@ rtl/core/sacc_cordic.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sacc_cordic
// Vectoring CORDIC, one iteration per register stage. Drives y to zero and
// accumulates the angle in turns.
// ----------------------------------------------------------------------------
module sacc_cordic #(
    parameter int STAGES = 16
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    output logic                 o_ready,
    input  wire sacc_pkg::t_vec  i_vec,
    output logic                 o_valid,
    input  wire                  i_ready,
    output sacc_pkg::t_vec       o_vec
);

    logic [STAGES-1:0] r_v;
    logic [STAGES:0]   w_rdy;
    sacc_pkg::t_vec    r_vec [STAGES];

    assign w_rdy[STAGES] = i_ready;
    assign o_ready       = w_rdy[0];

    for (genvar i = 0; i < STAGES; i++) begin : g_stage
        logic                           w_sv;
        sacc_pkg::t_vec                 w_src;
        sacc_pkg::t_vec                 n_vec;
        logic signed [sacc_pkg::CW-1:0] w_xs;
        logic signed [sacc_pkg::CW-1:0] w_ys;

        if (i == 0) begin : g_first
            assign w_sv  = i_valid;
            assign w_src = i_vec;
        end else begin : g_next
            assign w_sv  = r_v[i-1];
            assign w_src = r_vec[i-1];
        end

        assign w_rdy[i] = !r_v[i] || w_rdy[i+1];

        // One micro-rotation toward the x axis
        always_comb begin
            w_xs = w_src.x >>> i;
            w_ys = w_src.y >>> i;
            if (!w_src.y[sacc_pkg::CW-1]) begin
                n_vec.x = w_src.x + w_ys;
                n_vec.y = w_src.y - w_xs;
                n_vec.z = w_src.z + sacc_pkg::atan_turn(i);
            end else begin
                n_vec.x = w_src.x - w_ys;
                n_vec.y = w_src.y + w_xs;
                n_vec.z = w_src.z - sacc_pkg::atan_turn(i);
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[i] <= 1'b0;
            end else if (w_rdy[i]) begin
                r_v[i] <= w_sv;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_rdy[i] && w_sv) begin
                r_vec[i] <= n_vec;
            end
        end
    end

    assign o_valid = r_v[STAGES-1];
    assign o_vec   = r_vec[STAGES-1];

endmodule
`default_nettype wire

@@ rtl/core/sacc_phase.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sacc_phase
// Radius scaling, spiral phase and arm test, in four register stages; the
// last one is the output register.
// ----------------------------------------------------------------------------
module sacc_phase (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    output logic                 o_ready,
    input  wire sacc_pkg::t_vec  i_vec,
    input  wire  [17:0]          i_inverse_pitch,
    input  wire  [3:0]           i_arm_count,
    output logic                 o_valid,
    input  wire                  i_ready,
    output sacc_pkg::t_result    o_result
);

    // stage valids and readies: a, b, c, d
    logic r_va, r_vb, r_vc, r_vd;
    logic w_ra, w_rb, w_rc, w_rd;

    // stage a: x times inverse gain
    logic [30:0]               w_xm;
    logic [61:0]               r_pa;
    logic [sacc_pkg::AW-1:0]   r_za;
    // stage b: radius, near test, radius times inverse pitch
    logic [30:0]               w_rad;
    logic [48:0]               r_rt;
    logic [sacc_pkg::AW-1:0]   r_zb;
    logic                      r_nb;
    // stage c: phase and glyph
    logic [sacc_pkg::AW-1:0]   w_diff;
    logic [sacc_pkg::AW-1:0]   w_ph;
    logic [1:0]                n_glyph;
    logic [15:0]               r_p16;
    logic [1:0]                r_gc;
    logic                      r_nc;
    // stage d: result
    logic                      w_hit;
    sacc_pkg::t_result         n_res;
    sacc_pkg::t_result         r_res;

    assign w_rd    = !r_vd || i_ready;
    assign w_rc    = !r_vc || w_rd;
    assign w_rb    = !r_vb || w_rc;
    assign w_ra    = !r_va || w_rb;
    assign o_ready = w_ra;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
            r_vd <= 1'b0;
        end else begin
            if (w_ra) begin
                r_va <= i_valid;
            end
            if (w_rb) begin
                r_vb <= r_va;
            end
            if (w_rc) begin
                r_vc <= r_vb;
            end
            if (w_rd) begin
                r_vd <= r_vc;
            end
        end
    end

    // Stage a: clamp x at zero, scale by the inverse CORDIC gain
    assign w_xm = i_vec.x[sacc_pkg::CW-1] ? '0 : i_vec.x[30:0];

    always_ff @(posedge i_clk) begin
        if (w_ra && i_valid) begin
            r_pa <= {31'b0, w_xm} * {31'b0, sacc_pkg::INV_GAIN};
            r_za <= i_vec.z;
        end
    end

    // Stage b: radius in Q.16, radius in turns (Q.36 before the shift)
    assign w_rad = r_pa[61:31];

    always_ff @(posedge i_clk) begin
        if (w_rb && r_va) begin
            r_rt <= {18'b0, w_rad} * {31'b0, i_inverse_pitch};
            r_zb <= r_za;
            r_nb <= w_rad < sacc_pkg::MIN_RADIUS;
        end
    end

    // Stage c: phase, wrapped modulo one turn, and glyph from the half turn
    always_comb begin
        w_diff = r_zb - r_rt[35:4];
        w_ph   = w_diff * {28'b0, i_arm_count};
        case (r_zb[30:28])
            3'd1, 3'd2: n_glyph = sacc_pkg::GLYPH_BACK;
            3'd3, 3'd4: n_glyph = sacc_pkg::GLYPH_VERT;
            3'd5, 3'd6: n_glyph = sacc_pkg::GLYPH_SLASH;
            default:    n_glyph = sacc_pkg::GLYPH_HORIZ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_rc && r_vb) begin
            r_p16 <= w_ph[31:16];
            r_gc  <= n_glyph;
            r_nc  <= r_nb;
        end
    end

    // Stage d: arm test and result
    always_comb begin
        w_hit             = (r_p16 < sacc_pkg::ARM_LO) || (r_p16 > sacc_pkg::ARM_HI);
        n_res.near_centre = r_nc;
        n_res.on_arm      = w_hit && !r_nc;
        n_res.glyph       = (w_hit && !r_nc) ? r_gc : sacc_pkg::GLYPH_HORIZ;
    end

    always_ff @(posedge i_clk) begin
        if (w_rd && r_vc) begin
            r_res <= n_res;
        end
    end

    assign o_valid  = r_vd;
    assign o_result = r_res;

endmodule
`default_nettype wire

@@ rtl/core/spiral_arm_cell_classifier_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// spiral_arm_cell_classifier_unit
// Archimedean spiral pixel test: classifies one cell per clock unless stalled.
// ----------------------------------------------------------------------------
// Takes one cell beat per clock unless the result channel stalls, and returns
// one result beat per cell, in order. The pipeline has one offset stage, one
// stage per CORDIC iteration and four stages of radius scaling, phase and arm
// test; its stall-free throughput of one cell per cycle is set by the fully
// pipelined CORDIC, each iteration having its own adder stage. A stalled
// result beat holds in the output register while earlier stages keep
// filling their empty slots. The configuration port is always ready; write
// it only while no cell is in flight. There is no clearing pass after reset.
module spiral_arm_cell_classifier_unit #(
    parameter int PIXELS_PER_COL = 2,
    parameter int PIXELS_PER_ROW = 4,
    parameter int CORDIC_STAGES  = 16
) (
    input  wire             i_clk,
    input  wire             i_rst_n,
    sacc_cell_if.sink       i_cell,
    sacc_result_if.source   o_result,
    sacc_cfg_if.sink        i_cfg
);

    sacc_pkg::t_cfg    r_cfg;
    logic              w_off_v, w_off_r;
    sacc_pkg::t_vec    w_off_vec;
    logic              w_cor_v, w_cor_r;
    sacc_pkg::t_vec    w_cor_vec;
    sacc_pkg::t_result w_res;

    // Configuration registers
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.centre_col    <= sacc_pkg::RST_CENTRE_COL;
            r_cfg.centre_row    <= sacc_pkg::RST_CENTRE_ROW;
            r_cfg.inverse_pitch <= sacc_pkg::RST_INVERSE_PITCH;
            r_cfg.arm_count     <= sacc_pkg::RST_ARM_COUNT;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                sacc_pkg::CFG_CENTRE_COL:    r_cfg.centre_col    <= i_cfg.data[8:0];
                sacc_pkg::CFG_CENTRE_ROW:    r_cfg.centre_row    <= i_cfg.data[7:0];
                sacc_pkg::CFG_INVERSE_PITCH: r_cfg.inverse_pitch <= i_cfg.data[17:0];
                sacc_pkg::CFG_ARM_COUNT:     r_cfg.arm_count     <= i_cfg.data[3:0];
                default: begin
                end
            endcase
        end
    end

    // Offset from centre
    sacc_offset #(
        .PIXELS_PER_COL (PIXELS_PER_COL),
        .PIXELS_PER_ROW (PIXELS_PER_ROW)
    ) u_offset (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_cell.valid),
        .o_ready      (i_cell.ready),
        .i_col        (i_cell.cell_col),
        .i_row        (i_cell.cell_row),
        .i_centre_col (r_cfg.centre_col),
        .i_centre_row (r_cfg.centre_row),
        .o_valid      (w_off_v),
        .i_ready      (w_off_r),
        .o_vec        (w_off_vec)
    );

    // Radius and angle
    sacc_cordic #(
        .STAGES (CORDIC_STAGES)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_off_v),
        .o_ready (w_off_r),
        .i_vec   (w_off_vec),
        .o_valid (w_cor_v),
        .i_ready (w_cor_r),
        .o_vec   (w_cor_vec)
    );

    // Phase and arm test
    sacc_phase u_phase (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (w_cor_v),
        .o_ready         (w_cor_r),
        .i_vec           (w_cor_vec),
        .i_inverse_pitch (r_cfg.inverse_pitch),
        .i_arm_count     (r_cfg.arm_count),
        .o_valid         (o_result.valid),
        .i_ready         (o_result.ready),
        .o_result        (w_res)
    );

    assign o_result.on_arm      = w_res.on_arm;
    assign o_result.glyph       = w_res.glyph;
    assign o_result.near_centre = w_res.near_centre;

`ifndef SYNTHESIS
    // a skipped cell is never reported on an arm
    a_near_not_on_arm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |-> !(o_result.on_arm && o_result.near_centre))
        else $error("near-centre cell reported on an arm");

    // glyph is cleared off the arms
    a_glyph_off_arm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && !o_result.on_arm) |-> (o_result.glyph == sacc_pkg::GLYPH_HORIZ))
        else $error("glyph set on a cell off the arms");

    // reset empties the pipeline
    a_reset_flush: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_result.valid)
        else $error("result beat valid right after reset");
`endif

endmodule
`default_nettype wire
